/* sv/top_n_score_select_sort_macros.svh */
// Assertion macros for the top-n score selection block.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef TOP_N_SCORE_SELECT_SORT_MACROS_SVH
`define TOP_N_SCORE_SELECT_SORT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define TNSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define TNSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tnss_pkg.sv */
// Shared types, widths and the score key function for the top-n selection block.
// No dependencies; imported by tnss_cell and top_n_score_select_sort.
package tnss_pkg;

    localparam int KEY_W        = 32;
    localparam int WORD_W       = 32;
    localparam int BOX_WORDS    = 5;
    localparam int BOX_W        = WORD_W * BOX_WORDS;
    localparam int TOP_W        = 7;
    localparam int CAPACITY_DEF = 64;

    // One held proposal: ranking key and box words
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [BOX_W-1:0]  box;
    } t_entry;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the new proposal
        logic shift;  // move every entry one cell toward the head
        logic clear;  // drop all entries
    } t_cell_ctl;

    // Map float bits to an unsigned key that orders like the float; -0 ranks as +0
    function automatic logic [KEY_W-1:0] score_key(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] b;
        b = bits;
        if (b == {1'b1, {(KEY_W-1){1'b0}}}) begin
            b = '0;
        end
        if (b[KEY_W-1]) begin
            return ~b;
        end
        return b | {1'b1, {(KEY_W-1){1'b0}}};
    endfunction

endpackage

/* sv/tnss_cell.sv */
// One cell of the sorted insertion chain: holds a single ranked proposal.
// Depends on tnss_pkg for t_entry and t_cell_ctl.
module tnss_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tnss_pkg::t_cell_ctl i_ctl,
    input  tnss_pkg::t_entry   i_new,
    input  tnss_pkg::t_entry   i_prev,
    input  tnss_pkg::t_entry   i_next,
    input  logic               i_prev_lt,
    output logic               o_lt,
    output tnss_pkg::t_entry   o_entry
);
    import tnss_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [BOX_W-1:0] r_box;
    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [BOX_W-1:0] n_box;

    // Newcomer outranks this cell when the cell is empty or strictly lower
    assign o_lt    = !r_valid || (r_key < i_new.key);
    assign o_entry = '{valid: r_valid, key: r_key, box: r_box};

    // Pick next content: clear, shift toward head, take newcomer, take neighbor, or hold
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_box   = r_box;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_next.valid;
            n_key   = i_next.key;
            n_box   = i_next.box;
        end else if (i_ctl.ins && o_lt) begin
            if (i_prev_lt) begin
                n_valid = i_prev.valid;
                n_key   = i_prev.key;
                n_box   = i_prev.box;
            end else begin
                n_valid = i_new.valid;
                n_key   = i_new.key;
                n_box   = i_new.box;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_box <= n_box;
    end

endmodule

/* sv/top_n_score_select_sort.sv */
// Top level of the top-n score selection block: insertion chain plus emit control.
// Depends on tnss_pkg, tnss_cell and top_n_score_select_sort_macros.svh.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+------------------------------------------
//  slave     | in  | i_s_tvalid / o_s_tready   | i_s_tdata (score, box words 0..4), i_s_tlast
//  master    | out | o_m_tvalid / i_m_tready   | o_m_tdata (words 0..4), o_m_tlast, o_m_tuser
//  config    | in  | i_cfg_we                  | i_cfg_wdata (top_count)
//
// A proposal is inserted by a broadcast compare across all CAPACITY cells.
// After the word marked last, n words leave one per cycle from the head of the chain
// (n = top_count or the number held) while the master accepts; the slave side is
// closed during that emit phase. The output register lets the next set start while
// the last word waits. Master stalls hold the emit phase. Reset is synchronous.
`include "top_n_score_select_sort_macros.svh"

module top_n_score_select_sort #(
    parameter int CAPACITY = tnss_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [tnss_pkg::TOP_W-1:0]            i_cfg_wdata,
    // slave side
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // score [31:0], box_word0 [63:32] ... box_word4 [191:160]
    input  logic [tnss_pkg::KEY_W+tnss_pkg::BOX_W-1:0] i_s_tdata,
    input  logic                                  i_s_tlast,   // final_item
    // master side
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // out_word0 [31:0] ... out_word4 [159:128]
    output logic [tnss_pkg::BOX_W-1:0]            o_m_tdata,
    output logic                                  o_m_tlast,   // run_end
    output logic                                  o_m_tuser    // overflowed
);
    import tnss_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic [TOP_W-1:0] r_top;
    logic [CNT_W-1:0] r_held;
    logic [CNT_W-1:0] r_remain;
    logic             r_ovf;
    logic             r_ovalid;
    logic [BOX_W-1:0] r_odata;
    logic             r_olast;
    logic             r_ouser;

    logic             w_in_acc;
    logic             w_load;
    logic             w_done;
    logic             w_full;
    logic [CNT_W-1:0] w_held_next;
    logic [TOP_W-1:0] w_held_ext;
    logic [CNT_W-1:0] w_count;
    t_entry           w_new;
    t_cell_ctl        w_ctl;
    t_entry           w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_order_ok;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

    assign w_in_acc = i_s_tvalid && o_s_tready;
    assign w_load   = (r_state == ST_EMIT) && (!r_ovalid || i_m_tready);
    assign w_done   = w_load && (r_remain == CNT_W'(1));

    // Count after this insertion and the number of words to emit
    assign w_full      = (r_held == CNT_W'(CAPACITY));
    assign w_held_next = w_full ? r_held : r_held + CNT_W'(1);
    assign w_held_ext  = TOP_W'(w_held_next);
    assign w_count     = ((r_top != '0) && (r_top < w_held_ext)) ? CNT_W'(r_top) : w_held_next;

    assign w_new = '{valid: 1'b1,
                     key:   score_key(i_s_tdata[KEY_W-1:0]),
                     box:   i_s_tdata[KEY_W+BOX_W-1:KEY_W]};

    assign w_ctl = '{ins: w_in_acc, shift: w_load && !w_done, clear: w_done};

    // Build the chain of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_lt;
        if (gi == 0) begin : g_head
            assign w_prev    = '0;
            assign w_prev_lt = 1'b0;
        end else begin : g_body
            assign w_prev    = w_entry[gi-1];
            assign w_prev_lt = w_lt[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_entry[gi+1];
        end
        tnss_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new     (w_new),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_prev_lt (w_prev_lt),
            .o_lt      (w_lt[gi]),
            .o_entry   (w_entry[gi])
        );
        assign w_valid[gi] = w_entry[gi].valid;
        if (gi == 0) begin : g_ord_head
            assign w_order_ok[gi] = 1'b1;
        end else begin : g_ord_body
            assign w_order_ok[gi] = !w_entry[gi].valid ||
                (w_entry[gi-1].valid && (w_entry[gi-1].key >= w_entry[gi].key));
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_cfg_we) begin
            r_top <= i_cfg_wdata;
        end
    end

    // Set bookkeeping and emit sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_held   <= '0;
            r_remain <= '0;
            r_ovf    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_held <= w_held_next;
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_remain <= w_count;
                            r_state  <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_remain <= r_remain - CNT_W'(1);
                        if (w_done) begin
                            r_held  <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: load from the chain head, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
        if (w_load) begin
            r_odata <= w_entry[0].box;
            r_olast <= (r_remain == CNT_W'(1));
            r_ouser <= r_ovf;
        end
    end

    // Checks
    `TNSS_ASSERT_NOW(a_chain_sorted, 1'b1, &w_order_ok, "chain lost its ranking order")
    `TNSS_ASSERT_NOW(a_emit_nonzero, r_state == ST_EMIT, r_remain != '0, "emit with no words left")
    `TNSS_ASSERT_NOW(a_held_matches, r_state == ST_IDLE,
        $countones(w_valid) == int'(r_held), "held count disagrees with valid cells")
    `TNSS_ASSERT_NEXT(a_final_emits, w_in_acc && i_s_tlast, r_state == ST_EMIT,
        "final word did not start emit")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for top_n_score_select_sort: streams scored proposals and checks
// every ranked output word against a queue-based model of the sorted proposal store.
// Depends on tnss_pkg and the top_n_score_select_sort RTL.
module tb;
    import tnss_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int RAND_ITEMS = 400;
    localparam int DIR_N      = 25;
    localparam int CYCLE_CAP  = 300000;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE     = 8;
    localparam int DRAIN      = 20;
    localparam int REPORT_MAX = 10;

    typedef logic [BOX_W-1:0] t_box;

    // One held proposal in ranking order
    typedef struct {
        logic [KEY_W-1:0] key;
        t_box             box;
    } t_held;

    // One expected output word
    typedef struct {
        t_box box;
        logic run_end;
        logic spill;
    } t_word;

    // Directed stimulus row: optional top_count write before the proposal
    typedef struct packed {
        bit               cfg;
        logic [TOP_W-1:0] top;
        logic [31:0]      score;
        logic [31:0]      tag;
        bit               last;
        bit               lone;   // single-proposal set: its own box is the only word
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [TOP_W-1:0]          i_cfg_wdata;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [KEY_W+BOX_W-1:0]    i_s_tdata;
    logic                      i_s_tlast;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [BOX_W-1:0]          o_m_tdata;
    logic                      o_m_tlast;
    logic                      o_m_tuser;

    // Model of the sorted store and its pending output words
    t_held            rank_q[$];
    t_word            ranked_words_q[$];
    logic             spilled;
    logic [TOP_W-1:0] top_count;

    int    mismatches = 0;
    int    words_seen = 0;
    int    cycles     = 0;
    int    rx_wait    = 0;
    int    rx_streak  = 0;
    bit    m_fire     = 1'b0;
    bit    long_hold  = 1'b0;
    bit    hold_ask   = 1'b0;
    bit    calm       = 1'b0;
    t_word want;

    t_dir_row dir_rows [0:DIR_N-1] = '{
        // single-proposal sets at score extremes
        '{0, 7'd0,   32'h3F80_0000, 32'h0000_0000, 1, 1},
        '{0, 7'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1},
        '{0, 7'd0,   32'h0000_0000, 32'h0000_0001, 1, 1},
        '{0, 7'd0,   32'h8000_0000, 32'h0000_0002, 1, 1},
        '{0, 7'd0,   32'h7F80_0000, 32'h0000_0003, 1, 1},
        '{0, 7'd0,   32'h7FFF_FFFF, 32'h0000_0004, 1, 1},
        // -0 and +0 tie: arrival order holds
        '{0, 7'd0,   32'h8000_0000, 32'h0000_0010, 0, 0},
        '{0, 7'd0,   32'h0000_0000, 32'h0000_0011, 0, 0},
        '{0, 7'd0,   32'h8000_0000, 32'h0000_0012, 1, 0},
        // mixed signs and infinities
        '{0, 7'd0,   32'hBF80_0000, 32'h0000_0020, 0, 0},
        '{0, 7'd0,   32'h3F80_0000, 32'h0000_0021, 0, 0},
        '{0, 7'd0,   32'hFF80_0000, 32'h0000_0022, 0, 0},
        '{0, 7'd0,   32'h7F80_0000, 32'h0000_0023, 0, 0},
        '{0, 7'd0,   32'h0000_0001, 32'h0000_0024, 1, 0},
        // top_count of one
        '{1, 7'd1,   32'h4000_0000, 32'h0000_0030, 0, 0},
        '{0, 7'd0,   32'h4040_0000, 32'h0000_0031, 0, 0},
        '{0, 7'd0,   32'h4000_0000, 32'h0000_0032, 1, 0},
        // top_count of two over three equal scores
        '{1, 7'd2,   32'h3F80_0000, 32'h0000_0040, 0, 0},
        '{0, 7'd0,   32'h3F80_0000, 32'h0000_0041, 0, 0},
        '{0, 7'd0,   32'h3F80_0000, 32'h0000_0042, 1, 0},
        // top_count at capacity
        '{1, 7'd64,  32'hC000_0000, 32'h0000_0050, 0, 0},
        '{0, 7'd0,   32'h8000_0001, 32'h0000_0051, 1, 0},
        // top_count above range still emits all
        '{1, 7'd127, 32'h1234_5678, 32'h0000_0060, 1, 1},
        // back to emit-all
        '{1, 7'd0,   32'hAAAA_AAAA, 32'h5555_5555, 0, 0},
        '{0, 7'd0,   32'h5555_5555, 32'hAAAA_AAAA, 1, 0}
    };

    top_n_score_select_sort dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),     // score, box_word0 .. box_word4
        .i_s_tlast   (i_s_tlast),     // final_item
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),     // out_word0 .. out_word4
        .o_m_tlast   (o_m_tlast),     // run_end
        .o_m_tuser   (o_m_tuser)      // overflowed
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Insert one proposal into the ranked store; on the final one queue the best words if emit is set
    function automatic void rank_proposal(input logic [31:0] score, input t_box box,
                                          input bit last, input bit emit);
        t_held       h;
        t_word       w;
        logic [31:0] bits;
        int          pos;
        int          n;
        bits = (score == 32'h8000_0000) ? 32'h0 : score;
        h.key = bits[31] ? ~bits : {1'b1, bits[30:0]};
        h.box = box;
        pos = 0;
        while (pos < rank_q.size() && rank_q[pos].key >= h.key) pos++;
        if (rank_q.size() == CAP) begin
            // full: the lowest of CAP+1 falls off, a tie at the bottom drops the newcomer
            spilled = 1'b1;
            if (pos < CAP) begin
                rank_q.insert(pos, h);
                void'(rank_q.pop_back());
            end
        end else begin
            rank_q.insert(pos, h);
        end
        if (!last) return;
        n = rank_q.size();
        if (top_count != 0 && top_count < n) n = top_count;
        if (emit) begin
            for (int k = 0; k < n; k++) begin
                w.box     = rank_q[k].box;
                w.run_end = (k == n - 1);
                w.spill   = spilled;
                ranked_words_q.push_back(w);
            end
        end
        rank_q.delete();
        spilled = 1'b0;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch at word %0d, %s: expected %h, got %h",
                     words_seen, what, exp_val, got_val);
        end
    endtask

    // Offer one proposal after a random gap (none when calm) and hold it until accepted
    task automatic offer(input logic [31:0] score, input t_box box, input bit last,
                         input bit lone);
        int    gap;
        t_word w;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {box, score};
        i_s_tlast  <= last;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rank_proposal(score, box, last, !lone);
        if (lone) begin
            w.box     = box;
            w.run_end = 1'b1;
            w.spill   = 1'b0;
            ranked_words_q.push_back(w);
        end
    endtask

    // Drain, let the block settle, then write top_count
    task automatic write_top(input logic [TOP_W-1:0] value);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (ranked_words_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        top_count    = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check each accepted output word against the oldest expectation
    always @(posedge i_clk) begin
        m_fire = i_rst_n && o_m_tvalid && i_m_tready;
        if (m_fire) begin
            words_seen++;
            if (ranked_words_q.size() == 0) begin
                note_mismatch("word with nothing expected", 32'h0, o_m_tdata[WORD_W-1:0]);
            end else begin
                want = ranked_words_q.pop_front();
                for (int w = 0; w < BOX_WORDS; w++) begin
                    if (o_m_tdata[w*WORD_W +: WORD_W] !== want.box[w*WORD_W +: WORD_W]) begin
                        note_mismatch($sformatf("out_word%0d", w),
                                      want.box[w*WORD_W +: WORD_W],
                                      o_m_tdata[w*WORD_W +: WORD_W]);
                    end
                end
                if (o_m_tlast !== want.run_end) begin
                    note_mismatch("run_end", {31'h0, want.run_end}, {31'h0, o_m_tlast});
                end
                if (o_m_tuser !== want.spill) begin
                    note_mismatch("overflowed", {31'h0, want.spill}, {31'h0, o_m_tuser});
                end
            end
        end
    end

    // Receiver: random stall after each word, occasional streaks with no stall
    always @(negedge i_clk) begin
        if (m_fire) begin
            if (rx_streak > 0) begin
                rx_streak--;
            end else if ($urandom_range(0, 19) == 0) begin
                rx_streak = 20;
            end
            rx_wait = (rx_streak > 0) ? 0 : $urandom_range(0, 4);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !long_hold;
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_ask);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        int          sent;
        int          set_no;
        int          size;
        int          pick;
        bit          ties;
        logic [31:0] score;
        logic [31:0] tag;
        t_box        rbox;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        top_count   = '0;
        spilled     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].cfg) write_top(dir_rows[r].top);
            tag = dir_rows[r].tag;
            offer(dir_rows[r].score,
                  {tag ^ 32'hA5A5_A5A5, tag + 32'd1, tag ^ 32'h5A5A_5A5A, ~tag, tag},
                  dir_rows[r].last, dir_rows[r].lone);
        end

        // Random sets: mostly short, a few full or overflowing with heavy ties
        sent   = 0;
        set_no = 0;
        while (sent < RAND_ITEMS) begin
            if (set_no % 6 == 5) begin
                case ($urandom_range(0, 5))
                    0:       write_top('0);
                    1:       write_top(TOP_W'(1));
                    2:       write_top(TOP_W'(2));
                    3:       write_top(TOP_W'(CAP - 1));
                    4:       write_top(TOP_W'(CAP));
                    default: write_top(TOP_W'($urandom_range(0, 2**TOP_W - 1)));
                endcase
            end
            pick = $urandom_range(0, 19);
            if (pick == 0 || set_no == 2) begin
                size = CAP + $urandom_range(1, 6);
            end else if (pick == 1) begin
                size = CAP;
            end else begin
                size = $urandom_range(1, 8);
            end
            ties = (size >= CAP);
            calm = ($urandom_range(0, 4) == 0);
            if (set_no == 4) hold_ask = 1'b1;
            for (int i = 0; i < size; i++) begin
                case ($urandom_range(0, ties ? 5 : 9))
                    0:       score = 32'h0000_0000;
                    1:       score = 32'h8000_0000;
                    2:       score = 32'h3F80_0000;
                    3:       score = 32'hBF80_0000;
                    4:       score = $urandom_range(0, 1) ? 32'hFF80_0000 : 32'h7F80_0000;
                    5:       score = 32'h4049_0FDB;
                    default: score = $urandom();
                endcase
                rbox = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
                offer(score, rbox, i == size - 1, 1'b0);
            end
            sent += size;
            set_no++;
        end

        // Drain and finish
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (ranked_words_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
